[sv/ctsp_pkg.sv]
package ctsp_pkg;

	// string lengths
	localparam logic [4:0] SHORT_LEN   = 5'd13;
	localparam logic [4:0] LONG_LEN    = 5'd15;
	localparam int         DIGIT_SLOTS = 14;
	localparam logic [4:0] POS_MAX     = 5'd31;

	// character codes
	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_Z    = 8'h5A;

	// year window and field limits
	localparam logic [7:0]  YEAR_PIVOT_LO = 8'd50;
	localparam logic [7:0]  YEAR_PIVOT_HI = 8'd70;
	localparam logic [13:0] CENTURY_ADD   = 14'd100;
	localparam logic [13:0] BASE_YEAR     = 14'd1900;
	localparam logic [7:0]  MONTH_MAX     = 8'd12;
	localparam logic [7:0]  DAY_MAX       = 8'd31;
	localparam logic [7:0]  HOUR_MAX      = 8'd23;
	localparam logic [7:0]  MINSEC_MAX    = 8'd59;

	typedef logic [3:0] digit_t;

	// request handed from the front to the back part
	typedef struct packed {
		logic                         bad;
		logic                         short_form;
		digit_t [DIGIT_SLOTS-1:0]     digits;
	} job_t;

	// one finished result
	typedef struct packed {
		logic               parse_error;
		logic signed [13:0] year_offset;
		logic [3:0]         month_index;
		logic [4:0]         day_of_month;
		logic [4:0]         hour_value;
		logic [5:0]         minute_value;
		logic [5:0]         second_value;
	} result_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	// two decimal digits to a value, up to 165 for non-digit nibbles
	function automatic logic [7:0] two_dig(input digit_t hi, input digit_t lo);
		return 8'({4'd0, hi} * 8'd10) + {4'd0, lo};
	endfunction

endpackage

[sv/ctsp_front.sv]
module ctsp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [7:0]         char_in,
	input  logic               final_char,
	input  logic               queue_full,
	output logic               job_valid,
	output ctsp_pkg::job_t     job
);
	import ctsp_pkg::*;

	logic [4:0]  pos_q;
	logic [7:0]  prev_q;
	logic        nds_q;
	digit_t      digit_q [DIGIT_SLOTS];

	logic        accept;
	logic        is_nul;
	logic        prev_bad;
	logic        len_short;
	logic        len_long;
	logic [7:0]  last_char;

	assign accept = push && !queue_full;

	// classify the string on its final character
	always_comb begin
		is_nul    = (char_in == CHAR_NUL);
		prev_bad  = (pos_q != 5'd0) && !is_dec(prev_q);
		len_short = is_nul ? (pos_q == SHORT_LEN) : (pos_q == SHORT_LEN - 5'd1);
		len_long  = is_nul ? (pos_q == LONG_LEN) : (pos_q == LONG_LEN - 5'd1);
		last_char = is_nul ? prev_q : char_in;
		job.bad        = nds_q || (!is_nul && prev_bad) || !(len_short || len_long) ||
		                 (last_char != CHAR_Z);
		job.short_form = len_short;
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			job.digits[i] = digit_q[i];
		end
	end

	assign job_valid = accept && final_char;

	// per-string position, last character and non-digit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			prev_q <= '0;
			nds_q  <= 1'b0;
		end else if (accept) begin
			if (final_char) begin
				pos_q  <= '0;
				prev_q <= '0;
				nds_q  <= 1'b0;
			end else begin
				if (prev_bad) begin
					nds_q <= 1'b1;
				end
				prev_q <= char_in;
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 5'd1;
				end
			end
		end
	end

	// digit store, low nibble of each non-final character at positions below DIGIT_SLOTS
	always_ff @(posedge clk) begin
		if (accept && !final_char && (pos_q < 5'(DIGIT_SLOTS))) begin
			digit_q[pos_q[3:0]] <= char_in[3:0];
		end
	end

endmodule

[sv/ctsp_job_fifo.sv]
module ctsp_job_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ctsp_pkg::job_t     job_in,
	output logic               full,
	input  logic               pop,
	output ctsp_pkg::job_t     job_out,
	output logic               empty
);
	import ctsp_pkg::*;

	job_t        slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign job_out = slot_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= job_in;
		end
	end

endmodule

[sv/ctsp_back.sv]
module ctsp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ctsp_pkg::job_t     job,
	input  logic               job_empty,
	output logic               job_pop,
	input  logic               pop,
	output logic               empty,
	output ctsp_pkg::result_t  result
);
	import ctsp_pkg::*;

	logic [7:0]          pair [7];
	logic [7:0]          yr2;
	logic [7:0]          mon;
	logic [7:0]          day;
	logic [7:0]          hr;
	logic [7:0]          mi;
	logic [7:0]          se;
	logic signed [13:0]  yoff;
	logic                bad;
	result_t             res;

	result_t             slot_q [2];
	logic                wr_q;
	logic                rd_q;
	logic [1:0]          cnt_q;
	logic                do_pop;

	// two-digit groups at fixed offsets
	always_comb begin
		for (int k = 0; k < 7; k++) begin
			pair[k] = two_dig(job.digits[2*k], job.digits[2*k+1]);
		end
	end

	// field selection, year window and range checks
	always_comb begin
		yr2  = pair[0];
		bad  = job.bad;
		yoff = '0;
		if (job.short_form) begin
			mon = pair[1];
			day = pair[2];
			hr  = pair[3];
			mi  = pair[4];
			se  = pair[5];
			if (yr2 < YEAR_PIVOT_LO) begin
				yoff = signed'(14'(yr2) + CENTURY_ADD);
			end else if (yr2 < YEAR_PIVOT_HI) begin
				bad = 1'b1;
			end else begin
				yoff = signed'(14'(yr2));
			end
		end else begin
			mon  = pair[2];
			day  = pair[3];
			hr   = pair[4];
			mi   = pair[5];
			se   = pair[6];
			yoff = signed'(14'(14'(yr2) * 14'd100) + 14'(pair[1]) - BASE_YEAR);
		end
		if (mon < 8'd1 || mon > MONTH_MAX || day < 8'd1 || day > DAY_MAX ||
		    hr > HOUR_MAX || mi > MINSEC_MAX || se > MINSEC_MAX) begin
			bad = 1'b1;
		end
		if (bad) begin
			res = '0;
			res.parse_error = 1'b1;
		end else begin
			res.parse_error  = 1'b0;
			res.year_offset  = yoff;
			res.month_index  = 4'(mon - 8'd1);
			res.day_of_month = day[4:0];
			res.hour_value   = hr[4:0];
			res.minute_value = mi[5:0];
			res.second_value = se[5:0];
		end
	end

	// take a request whenever the result buffer has room
	assign job_pop = !job_empty && (cnt_q != 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_pop  = pop && !empty;
	assign result  = slot_q[rd_q];

	// result buffer pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (job_pop) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, job_pop} - {1'b0, do_pop};
		end
	end

	// result buffer storage
	always_ff @(posedge clk) begin
		if (job_pop) begin
			slot_q[wr_q] <= res;
		end
	end

endmodule

[sv/cert_time_string_parser_core.sv]
// channel   handshake        payload
// input     push / full      char_in, final_char
// result    empty / pop      parse_error, year_offset, month_index, day_of_month,
//                            hour_value, minute_value, second_value
//
// one character is taken per cycle while full is low; a final character's request
// reaches the two-entry result buffer, where pop can take it, through these steps
// (front classify, two-entry queue register, back compute into the result buffer)
// the back part finishes one request per cycle while the result buffer has room
// full rises only when the middle queue holds two requests; pop stalls back up
// arst_n clears position, flags, queue and buffer counts; no clearing pass
module cert_time_string_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         char_in,
	input  logic               final_char,
	output logic               empty,
	input  logic               pop,
	output logic               parse_error,
	output logic signed [13:0] year_offset,
	output logic [3:0]         month_index,
	output logic [4:0]         day_of_month,
	output logic [4:0]         hour_value,
	output logic [5:0]         minute_value,
	output logic [5:0]         second_value
);
	import ctsp_pkg::*;

	job_t     job_f;
	job_t     job_b;
	logic     job_valid;
	logic     job_empty;
	logic     job_pop;
	result_t  res;

	// front: position tracking and classification
	ctsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.char_in    (char_in),
		.final_char (final_char),
		.queue_full (full),
		.job_valid  (job_valid),
		.job        (job_f)
	);

	// queue between front and back
	ctsp_job_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_valid),
		.job_in  (job_f),
		.full    (full),
		.pop     (job_pop),
		.job_out (job_b),
		.empty   (job_empty)
	);

	// back: field decode and result buffer
	ctsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_b),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (res)
	);

	assign parse_error  = res.parse_error;
	assign year_offset  = res.year_offset;
	assign month_index  = res.month_index;
	assign day_of_month = res.day_of_month;
	assign hour_value   = res.hour_value;
	assign minute_value = res.minute_value;
	assign second_value = res.second_value;

endmodule

[sv/ctsp_checker.sv]
module ctsp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  logic               pop,
	input  logic               parse_error,
	input  logic signed [13:0] year_offset,
	input  logic [3:0]         month_index,
	input  logic [4:0]         day_of_month,
	input  logic [4:0]         hour_value,
	input  logic [5:0]         minute_value,
	input  logic [5:0]         second_value
);

	// a waiting result that is not taken stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(parse_error) && $stable(year_offset) &&
		$stable(month_index) && $stable(day_of_month) && $stable(hour_value) &&
		$stable(minute_value) && $stable(second_value)))
		else $error("result changed while stalled");

	// an error result carries all-zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && parse_error) |-> (year_offset == 14'sd0 && month_index == 4'd0 &&
		day_of_month == 5'd0 && hour_value == 5'd0 && minute_value == 6'd0 &&
		second_value == 6'd0))
		else $error("error result with nonzero fields");

	// a good result lies within calendar ranges
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !parse_error) |-> (month_index <= 4'd11 && day_of_month != 5'd0 &&
		hour_value <= 5'd23 && minute_value <= 6'd59 && second_value <= 6'd59))
		else $error("good result out of range");

	// the year never falls before year zero
	a_year: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !parse_error) |-> (year_offset >= -14'sd1900))
		else $error("year offset below floor");

endmodule

bind cert_time_string_parser_core ctsp_checker u_ctsp_checker (.*);
